[rtl/core/domq_pkg.sv]
// ----------------------------------------------------------------------------
// domq_pkg: shared types and constants
// entry layout, cell control, controller states and status codes for the
// deadline ordered message queue
// ----------------------------------------------------------------------------
`default_nettype none

package domq_pkg;

    localparam int DEADLINE_W = 32;
    localparam int PAYLOAD_W  = 32;
    localparam int KIND_W     = 2;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int DELAY_W    = 24;
    localparam int RUN_W      = 2;

    // most messages handed out by one tick
    localparam int MAX_BURST  = 16;
    localparam int BURST_W    = $clog2(MAX_BURST);

    // input actions
    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POST  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

    // message kinds
    localparam logic [KIND_W-1:0] KIND_ASYNC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYNC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT  = 2'd2;

    // run states
    localparam logic [RUN_W-1:0] RUN_UNSTARTED = 2'd0;
    localparam logic [RUN_W-1:0] RUN_RUNNING   = 2'd1;
    localparam logic [RUN_W-1:0] RUN_STOPPED   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_POSTED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TASK        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXIT        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STARTED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_REFUSED     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOTHING_DUE = 3'd7;

    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [PAYLOAD_W-1:0]  payload;
        logic [KIND_W-1:0]     kind;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } cell_link_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPLY,
        S_INSERT,
        S_DISPATCH
    } ctrl_state_t;

    // wrap-safe: a is due no later than b
    function automatic logic not_later(input logic [DEADLINE_W-1:0] a,
                                       input logic [DEADLINE_W-1:0] b);
        logic [DEADLINE_W-1:0] diff;
        diff = a - b;
        return (diff == '0) || diff[DEADLINE_W-1];
    endfunction

endpackage

`default_nettype wire

[rtl/core/deadline_ordered_message_queue.sv]
// ----------------------------------------------------------------------------
// deadline_ordered_message_queue: pool of pending messages sorted by due time
// a chain of cells keeps entries in dispatch order; a small controller
// decodes start, post and tick transactions and drives the chain
// ----------------------------------------------------------------------------
// order: a start or post is taken in S_IDLE and gives its single result from
//   S_REPLY or S_INSERT into the output register; a tick gives its results from
//   S_DISPATCH, one a cycle while the result port is not stalled; the next
//   transaction is taken only back in S_IDLE, so one item is in work at a time,
//   set by the single insert/pop port of the cell chain
// reset: queue unstarted, clock at zero, pool empty; no clearing pass
`default_nettype none

module deadline_ordered_message_queue #(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // delay[23:0], task_word[55:24]
    input  wire logic [3:0]  s_axis_tuser,   // action[1:0], msg_kind[3:2]
    // result transactions
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // task_out[31:0]
    output logic [3:0]       m_axis_tuser,   // status[2:0], sync_done[3]
    output logic             m_axis_tlast
);

    // ------------------------------------------------------------------------
    // input field unpacking
    // ------------------------------------------------------------------------
    logic [domq_pkg::ACTION_W-1:0]   in_action;
    logic [domq_pkg::KIND_W-1:0]     in_kind;
    logic [domq_pkg::DELAY_W-1:0]    in_delay;
    logic [domq_pkg::PAYLOAD_W-1:0]  in_task;

    assign in_action = s_axis_tuser[1:0];
    assign in_kind   = s_axis_tuser[3:2];
    assign in_delay  = s_axis_tdata[23:0];
    assign in_task   = s_axis_tdata[55:24];

    // ------------------------------------------------------------------------
    // controller state
    // ------------------------------------------------------------------------
    domq_pkg::ctrl_state_t              state_reg, state_next;
    logic [domq_pkg::RUN_W-1:0]         run_reg, run_next;
    logic [domq_pkg::DEADLINE_W-1:0]    now_reg, now_next;
    logic [domq_pkg::BURST_W-1:0]       burst_reg, burst_next;
    logic [domq_pkg::STATUS_W-1:0]      reply_reg, reply_next;
    domq_pkg::entry_t                   ins_reg, ins_next;

    // output register: lets the next transaction in while a result waits
    logic                               out_valid_reg, out_valid_next;
    logic [domq_pkg::STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [domq_pkg::PAYLOAD_W-1:0]     out_task_reg, out_task_next;
    logic                               out_sync_reg, out_sync_next;
    logic                               out_last_reg, out_last_next;
    logic                               out_free;

    // ------------------------------------------------------------------------
    // cell chain wiring; index SLOTS is an always-empty slot past the tail
    // ------------------------------------------------------------------------
    domq_pkg::cell_ctrl_t               cell_ctrl;
    logic [domq_pkg::DEADLINE_W-1:0]    key;
    domq_pkg::cell_link_t               cells [0:SLOTS];
    logic                               le [0:SLOTS];
    logic                               pass [0:SLOTS-1];
    logic                               pool_full;
    logic                               head_due;
    logic                               next_due;

    assign cells[SLOTS] = '0;
    assign le[SLOTS]    = 1'b0;

    // the insert compares every cell with the new deadline, a tick compares
    // the head cells with the advanced clock
    assign key = (state_reg == domq_pkg::S_INSERT) ? ins_reg.deadline : now_reg;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            domq_pkg::cell_link_t left_link;
            if (g == 0)
            begin : g_head
                assign left_link = '0;
                assign pass[g]   = 1'b1;
            end
            else
            begin : g_body
                // pass marks that every cell to the left keeps its entry
                assign left_link = cells[g-1];
                assign pass[g]   = pass[g-1] && le[g-1];
            end

            domq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .key      (key),
                .pass_in  (pass[g]),
                .left_in  (left_link),
                .right_in (cells[g+1]),
                .cell_out (cells[g]),
                .le       (le[g])
            );
        end
    endgenerate

    // valid cells always form a prefix, so the tail cell tells fullness
    assign pool_full = cells[SLOTS-1].valid;
    assign head_due  = (run_reg == domq_pkg::RUN_RUNNING) && le[0];
    // the entry behind the head is due too and the burst limit is not reached
    assign next_due  = le[1] && (burst_reg != domq_pkg::BURST_W'(domq_pkg::MAX_BURST - 1));

    assign out_free  = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------------
    // next state and outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        run_next        = run_reg;
        now_next        = now_reg;
        burst_next      = burst_reg;
        reply_next      = reply_reg;
        ins_next        = ins_reg;
        cell_ctrl.op    = domq_pkg::CELL_HOLD;
        cell_ctrl.ins   = ins_reg;
        s_axis_tready   = 1'b0;

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        out_sync_next   = out_sync_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            domq_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    unique case (in_action)
                        domq_pkg::ACT_START:
                        begin
                            if (run_reg == domq_pkg::RUN_UNSTARTED)
                            begin
                                run_next   = domq_pkg::RUN_RUNNING;
                                reply_next = domq_pkg::ST_STARTED;
                            end
                            else
                            begin
                                reply_next = domq_pkg::ST_REFUSED;
                            end
                            state_next = domq_pkg::S_REPLY;
                        end
                        domq_pkg::ACT_POST:
                        begin
                            if (run_reg != domq_pkg::RUN_RUNNING)
                            begin
                                reply_next = domq_pkg::ST_NOT_RUNNING;
                                state_next = domq_pkg::S_REPLY;
                            end
                            else if (pool_full)
                            begin
                                reply_next = domq_pkg::ST_POOL_FULL;
                                state_next = domq_pkg::S_REPLY;
                            end
                            else
                            begin
                                // only async posts wait; others are due now
                                ins_next.deadline = (in_kind == domq_pkg::KIND_ASYNC)
                                    ? now_reg + domq_pkg::DEADLINE_W'(in_delay)
                                    : now_reg;
                                ins_next.payload  = (in_kind == domq_pkg::KIND_EXIT)
                                    ? '0 : in_task;
                                ins_next.kind     = in_kind;
                                state_next        = domq_pkg::S_INSERT;
                            end
                        end
                        domq_pkg::ACT_TICK:
                        begin
                            // the clock advances even when not running
                            now_next   = now_reg + 1'b1;
                            burst_next = '0;
                            state_next = domq_pkg::S_DISPATCH;
                        end
                        default:
                        begin
                            // unknown action: taken and dropped, no result
                        end
                    endcase
                end
            end

            domq_pkg::S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = reply_reg;
                    out_task_next   = '0;
                    out_sync_next   = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = domq_pkg::S_IDLE;
                end
            end

            domq_pkg::S_INSERT:
            begin
                if (out_free)
                begin
                    cell_ctrl.op    = domq_pkg::CELL_INSERT;
                    out_valid_next  = 1'b1;
                    out_status_next = domq_pkg::ST_POSTED;
                    out_task_next   = '0;
                    out_sync_next   = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = domq_pkg::S_IDLE;
                end
            end

            domq_pkg::S_DISPATCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_task_next  = '0;
                    out_sync_next  = 1'b0;
                    out_last_next  = 1'b1;
                    if (!head_due)
                    begin
                        // only reached on the first step of a tick
                        out_status_next = domq_pkg::ST_NOTHING_DUE;
                        state_next      = domq_pkg::S_IDLE;
                    end
                    else if (cells[0].entry.kind == domq_pkg::KIND_EXIT)
                    begin
                        // exit stops the queue and drops the rest of the pool
                        out_status_next = domq_pkg::ST_EXIT;
                        cell_ctrl.op    = domq_pkg::CELL_CLEAR;
                        run_next        = domq_pkg::RUN_STOPPED;
                        state_next      = domq_pkg::S_IDLE;
                    end
                    else
                    begin
                        out_status_next = domq_pkg::ST_TASK;
                        out_task_next   = cells[0].entry.payload;
                        out_sync_next   = (cells[0].entry.kind == domq_pkg::KIND_SYNC);
                        out_last_next   = !next_due;
                        cell_ctrl.op    = domq_pkg::CELL_POP;
                        burst_next      = burst_reg + 1'b1;
                        if (!next_due)
                        begin
                            state_next = domq_pkg::S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = domq_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= domq_pkg::S_IDLE;
            run_reg       <= domq_pkg::RUN_UNSTARTED;
            now_reg       <= '0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            now_reg       <= now_next;
            burst_reg     <= burst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        reply_reg      <= reply_next;
        ins_reg        <= ins_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
        out_sync_reg   <= out_sync_next;
        out_last_reg   <= out_last_next;
    end

    // ------------------------------------------------------------------------
    // result port
    // ------------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_task_reg;
    assign m_axis_tuser  = {out_sync_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/core/domq_cell.sv]
// ----------------------------------------------------------------------------
// domq_cell: one slot of the sorted message chain
// holds one entry, compares its deadline with the shared key and shifts
// toward either neighbor on insert or pop
// ----------------------------------------------------------------------------
`default_nettype none

module domq_cell (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire domq_pkg::cell_ctrl_t                 ctrl,
    input  wire logic [domq_pkg::DEADLINE_W-1:0]      key,
    input  wire logic                                 pass_in,
    input  wire domq_pkg::cell_link_t                 left_in,
    input  wire domq_pkg::cell_link_t                 right_in,
    output domq_pkg::cell_link_t                      cell_out,
    output logic                                      le
);

    logic              valid_reg;
    logic              valid_next;
    domq_pkg::entry_t  entry_reg;
    domq_pkg::entry_t  entry_next;

    assign le = valid_reg && domq_pkg::not_later(entry_reg.deadline, key);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        unique case (ctrl.op)
            domq_pkg::CELL_HOLD:
            begin
            end
            domq_pkg::CELL_INSERT:
            begin
                if (pass_in && !le)
                begin
                    // first slot that is empty or whose entry is due after the new one
                    valid_next = 1'b1;
                    entry_next = ctrl.ins;
                end
                else if (!pass_in)
                begin
                    valid_next = left_in.valid;
                    entry_next = left_in.entry;
                end
            end
            domq_pkg::CELL_POP:
            begin
                valid_next = right_in.valid;
                entry_next = right_in.entry;
            end
            domq_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.entry = entry_reg;

endmodule

`default_nettype wire
